FILE: design/record_selection_sorter_assert.svh
// assertion macros shared by the record selection sorter checks
`ifndef RECORD_SELECTION_SORTER_ASSERT_SVH
`define RECORD_SELECTION_SORTER_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge
`define RSS_CHK_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("record sorter check failed");

// next-cycle implication, sampled on the rising clock edge
`define RSS_CHK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("record sorter check failed");

`endif

FILE: design/rss_pkg.sv
// types and constants of the record selection sorter
package rss_pkg;

  localparam int TAG_W = 17;
  localparam int KEY_W = 34;
  localparam int REC_W = KEY_W + TAG_W;

  // input beat: one record of the set
  typedef struct packed {
    logic [16:0] tag_number;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic        last_record;
  } rss_in_t;

  // result beat: one record in sorted order
  typedef struct packed {
    logic [16:0] out_tag_number;
    logic [13:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic        out_last;
    logic        overflowed;
  } rss_out_t;

  // sort key, most significant part first
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } rss_key_t;

  // stored record
  typedef struct packed {
    rss_key_t    key;
    logic [16:0] tag;
  } rss_rec_t;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_SCAN,
    ST_EMIT
  } rss_state_t;

endpackage

FILE: design/record_selection_sorter.sv
// record selection sorter top level: fill, scan and emit control around the store
//
//   channel | ports                      | handshake
//   --------+----------------------------+-----------------------------------
//   input   | start, busy, in_data       | beat taken when start && !busy
//   result  | out_valid, out_data        | one-cycle strobe, no back pressure
//
// input beats are accepted back to back while the set is filling; the closing
// beat starts a sort in which each position costs one store read per remaining
// record, then a wait for the registered read data and the emit state; all
// reads go through the single store read port.
// reset is synchronous; the store needs no clearing, only written entries
// are read. the receiver cannot stall: each result shows for one cycle.
module record_selection_sorter #(
  parameter int DEPTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  rss_pkg::rss_in_t in_data,
  output logic             out_valid,
  output rss_pkg::rss_out_t out_data
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rss_pkg::rss_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic [IW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] iss_r, iss_nxt;
  logic          dv_r, dv_nxt;
  logic [IW-1:0] q_r, q_nxt;
  logic [IW-1:0] min_idx_r, min_idx_nxt;
  rss_pkg::rss_rec_t min_r, min_nxt;
  rss_pkg::rss_rec_t base_r, base_nxt;

  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  rss_pkg::rss_rec_t mem_wdata;
  logic [IW-1:0]     mem_raddr;
  rss_pkg::rss_rec_t mem_rdata;
  rss_pkg::rss_rec_t rec_in;
  logic [rss_pkg::KEY_W-1:0] rd_key;
  logic [rss_pkg::KEY_W-1:0] min_key;

  // incoming beat as a stored record
  always_comb begin
    rec_in.key.year   = in_data.year;
    rec_in.key.month  = in_data.month;
    rec_in.key.day    = in_data.day;
    rec_in.key.hour   = in_data.hour;
    rec_in.key.minute = in_data.minute;
    rec_in.tag        = in_data.tag_number;
  end

  assign rd_key  = mem_rdata.key;
  assign min_key = min_r.key;

  rss_store #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rss_pkg::ST_FILL;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      dv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      dv_r    <= dv_nxt;
    end
  end

  // scan pointers and running minimum
  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    iss_r     <= iss_nxt;
    q_r       <= q_nxt;
    min_idx_r <= min_idx_nxt;
    min_r     <= min_nxt;
    base_r    <= base_nxt;
  end

  // next state, store access and result
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    ovf_nxt     = ovf_r;
    pos_nxt     = pos_r;
    iss_nxt     = iss_r;
    dv_nxt      = 1'b0;
    q_nxt       = q_r;
    min_idx_nxt = min_idx_r;
    min_nxt     = min_r;
    base_nxt    = base_r;
    mem_we      = 1'b0;
    mem_waddr   = cnt_r[IW-1:0];
    mem_wdata   = rec_in;
    mem_raddr   = iss_r[IW-1:0];
    busy        = (state_r != rss_pkg::ST_FILL);
    out_valid   = 1'b0;
    out_data.out_tag_number = min_r.tag;
    out_data.out_year       = min_r.key.year;
    out_data.out_month      = min_r.key.month;
    out_data.out_day        = min_r.key.day;
    out_data.out_hour       = min_r.key.hour;
    out_data.out_minute     = min_r.key.minute;
    out_data.out_last       = ((CW'(pos_r) + CW'(1)) == cnt_r);
    out_data.overflowed     = ovf_r;
    case (state_r)
      rss_pkg::ST_FILL: begin
        if (start) begin
          // store the record or drop it when full
          if (cnt_r < CW'(DEPTH)) begin
            mem_we  = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.last_record) begin
            state_nxt = rss_pkg::ST_SCAN;
            pos_nxt   = '0;
            iss_nxt   = '0;
          end
        end
      end
      rss_pkg::ST_SCAN: begin
        // issue reads from the current position to the end of the set
        if (iss_r < cnt_r) begin
          iss_nxt = iss_r + CW'(1);
          dv_nxt  = 1'b1;
          q_nxt   = iss_r[IW-1:0];
        end
        // fold returning data into the running minimum
        if (dv_r) begin
          if (q_r == pos_r) begin
            min_nxt     = mem_rdata;
            min_idx_nxt = q_r;
            base_nxt    = mem_rdata;
          end else if (rd_key < min_key) begin
            min_nxt     = mem_rdata;
            min_idx_nxt = q_r;
          end
          if ((CW'(q_r) + CW'(1)) == cnt_r) begin
            state_nxt = rss_pkg::ST_EMIT;
          end
        end
      end
      rss_pkg::ST_EMIT: begin
        // emit the minimum, move the displaced record into its slot
        out_valid = 1'b1;
        mem_we    = 1'b1;
        mem_waddr = min_idx_r;
        mem_wdata = base_r;
        if ((CW'(pos_r) + CW'(1)) == cnt_r) begin
          state_nxt = rss_pkg::ST_FILL;
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
        end else begin
          state_nxt = rss_pkg::ST_SCAN;
          pos_nxt   = pos_r + IW'(1);
          iss_nxt   = CW'(pos_r) + CW'(1);
        end
      end
      default: begin
        state_nxt = rss_pkg::ST_FILL;
      end
    endcase
  end

endmodule

FILE: design/rss_store.sv
// record store: one write port, one read port with registered read data
module rss_store #(
  parameter int DEPTH = 32,
  parameter int IW    = 5
) (
  input  logic              clk,
  input  logic              we,
  input  logic [IW-1:0]     waddr,
  input  rss_pkg::rss_rec_t wdata,
  input  logic [IW-1:0]     raddr,
  output rss_pkg::rss_rec_t rdata
);

  rss_pkg::rss_rec_t mem [DEPTH];
  rss_pkg::rss_rec_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/rss_checker.sv
// port-level checks of the record selection sorter and their bind
`include "record_selection_sorter_assert.svh"

module rss_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input rss_pkg::rss_in_t  in_data,
  input logic              out_valid,
  input rss_pkg::rss_out_t out_data
);

  // results only appear while a set is being sorted
  `RSS_CHK_SAME(a_out_while_busy, out_valid, busy)

  // a closing beat starts the sort, with no result in the next cycle
  `RSS_CHK_NEXT(a_close_starts_sort, start && !busy && in_data.last_record, busy && !out_valid)

  // the final result of a set returns the block to idle
  `RSS_CHK_NEXT(a_last_frees, out_valid && out_data.out_last, !busy)

  // a result that is not final is followed by another scan
  `RSS_CHK_NEXT(a_more_follows, out_valid && !out_data.out_last, busy && !out_valid)

endmodule

bind record_selection_sorter rss_checker u_rss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
